// ----- rtl/core/mm_pkg.sv -----
package mm_pkg;

	typedef enum logic [1:0] {
		CMD_WR_A = 2'd0,
		CMD_WR_B = 2'd1,
		CMD_CALC = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	localparam logic [1:0] CFG_A_ROWS = 2'd0;
	localparam logic [1:0] CFG_A_COLS = 2'd1;
	localparam logic [1:0] CFG_B_ROWS = 2'd2;
	localparam logic [1:0] CFG_B_COLS = 2'd3;

	localparam logic [3:0] DIM_RESET = 4'd8;
	localparam int FRAC_BITS = 16;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;

	typedef struct packed {
		logic [1:0]         command;
		logic [2:0]         row_index;
		logic [2:0]         col_index;
		logic signed [31:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic signed [31:0] out_value;
		logic               size_error;
		logic               last;
	} out_item_t;

	typedef struct packed {
		cmd_t               op;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
	} job_t;

	typedef struct packed {
		logic [3:0] a_rows;
		logic [3:0] a_cols;
		logic [3:0] b_rows;
		logic [3:0] b_cols;
	} dims_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       lastk;
		logic       last;
		logic       err;
		logic [2:0] row;
		logic [2:0] col;
	} tag_t;

endpackage

// ----- rtl/core/mm_front.sv -----
module mm_front #(
	parameter int MAX_DIM = 8
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  mm_pkg::in_item_t  in_data,
	input  mm_pkg::q_stat_t   q_stat,
	output logic              push,
	output mm_pkg::job_t      push_data
);

	logic row_ok;
	logic col_ok;
	logic keep;

	assign in_ready = !q_stat.full;

	always_comb begin
		row_ok = int'(in_data.row_index) < MAX_DIM;
		col_ok = int'(in_data.col_index) < MAX_DIM;
		case (in_data.command)
			mm_pkg::CMD_WR_A, mm_pkg::CMD_WR_B: begin
				keep = row_ok && col_ok;
			end
			mm_pkg::CMD_CALC: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		push_data.op    = mm_pkg::cmd_t'(in_data.command);
		push_data.row   = in_data.row_index;
		push_data.col   = in_data.col_index;
		push_data.value = in_data.entry_value;
	end

	assign push = in_valid && in_ready && keep;

endmodule

// ----- rtl/core/mm_queue.sv -----
module mm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mm_pkg::job_t    push_data,
	input  logic            pop,
	output mm_pkg::job_t    pop_data,
	output mm_pkg::q_stat_t q_stat
);

	mm_pkg::job_t                mem_q [mm_pkg::Q_DEPTH];
	logic [mm_pkg::Q_AW-1:0]     wr_q;
	logic [mm_pkg::Q_AW-1:0]     rd_q;
	logic [mm_pkg::Q_AW:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data     = mem_q[rd_q];
	assign q_stat.full  = cnt_q == (mm_pkg::Q_AW + 1)'(mm_pkg::Q_DEPTH);
	assign q_stat.empty = cnt_q == '0;

endmodule

// ----- rtl/core/mm_back.sv -----
module mm_back #(
	parameter int MAX_DIM    = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mm_pkg::dims_t     dims,
	input  mm_pkg::q_stat_t   q_stat,
	input  mm_pkg::job_t      pop_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output mm_pkg::out_item_t out_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int VB    = VALUE_BITS;
	localparam int H     = VB / 2;
	localparam int PW    = 2 * VB;
	localparam int ACC_W = PW + $clog2(MAX_DIM) + 1;
	localparam int TW    = ACC_W - mm_pkg::FRAC_BITS;

	function automatic logic [3:0] used_m1(input logic [3:0] d);
		logic [3:0] u;
		if (d == 4'd0) begin
			u = 4'd1;
		end else if (int'(d) > MAX_DIM) begin
			u = 4'(MAX_DIM);
		end else begin
			u = d;
		end
		return u - 4'd1;
	endfunction

	logic [VB-1:0] a_mem [DEPTH];
	logic [VB-1:0] b_mem [DEPTH];

	mm_pkg::seq_state_t state_q, state_n;
	logic [IW-1:0] i_q, j_q, k_q, i_n, j_n, k_n;
	logic [IW-1:0] ar_m1_q, ac_m1_q, bc_m1_q;
	logic          dims_ld;
	logic          size_err;
	logic          adv;
	logic          we_a, we_b;
	logic [AW-1:0] wr_addr, ra, rb;
	logic [VB-1:0] wv;
	mm_pkg::tag_t  iss;

	mm_pkg::tag_t            tag_s1, tag_s2, tag_s3;
	logic signed [VB-1:0]    a_rd_s1, b_rd_s1;
	logic signed [H:0]       b_lo;
	logic signed [VB-H-1:0]  b_hi;
	logic signed [VB+H:0]    p_lo_s2;
	logic signed [PW-H-1:0]  p_hi_s2;
	logic signed [PW-1:0]    prod_s3;
	logic signed [ACC_W-1:0] acc_s4;
	logic signed [ACC_W-1:0] acc_base;
	logic                    emit_s4;
	logic                    err_s4, last_s4;
	logic [2:0]              row_s4, col_s4;
	logic signed [TW-1:0]    t_sh;
	logic [TW-VB:0]          t_hi;
	logic [VB-1:0]           sat;
	logic                    out_valid_q;
	mm_pkg::out_item_t       out_q;

	assign adv      = !out_valid_q || out_ready;
	assign size_err = used_m1(dims.a_cols) != used_m1(dims.b_rows);
	assign wr_addr  = AW'(pop_data.row) * AW'(MAX_DIM) + AW'(pop_data.col);
	assign wv       = VB'(pop_data.value);
	assign ra       = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
	assign rb       = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_n;
			i_q     <= i_n;
			j_q     <= j_n;
			k_q     <= k_n;
		end
	end

	always_ff @(posedge clk) begin
		if (dims_ld) begin
			ar_m1_q <= IW'(used_m1(dims.a_rows));
			ac_m1_q <= IW'(used_m1(dims.a_cols));
			bc_m1_q <= IW'(used_m1(dims.b_cols));
		end
	end

	always_comb begin
		state_n = state_q;
		i_n     = i_q;
		j_n     = j_q;
		k_n     = k_q;
		pop     = 1'b0;
		we_a    = 1'b0;
		we_b    = 1'b0;
		dims_ld = 1'b0;
		iss     = '0;
		case (state_q)
			mm_pkg::ST_IDLE: begin
				if (adv && !q_stat.empty) begin
					pop = 1'b1;
					case (pop_data.op)
						mm_pkg::CMD_WR_A: begin
							we_a = 1'b1;
						end
						mm_pkg::CMD_WR_B: begin
							we_b = 1'b1;
						end
						mm_pkg::CMD_CALC: begin
							if (size_err) begin
								iss.valid = 1'b1;
								iss.first = 1'b1;
								iss.lastk = 1'b1;
								iss.last  = 1'b1;
								iss.err   = 1'b1;
							end else begin
								dims_ld = 1'b1;
								i_n     = '0;
								j_n     = '0;
								k_n     = '0;
								state_n = mm_pkg::ST_RUN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			mm_pkg::ST_RUN: begin
				if (adv) begin
					iss.valid = 1'b1;
					iss.first = k_q == '0;
					iss.lastk = k_q == ac_m1_q;
					iss.last  = (i_q == ar_m1_q) && (j_q == bc_m1_q);
					iss.row   = 3'(i_q);
					iss.col   = 3'(j_q);
					if (k_q != ac_m1_q) begin
						k_n = k_q + 1'b1;
					end else begin
						k_n = '0;
						if (j_q != bc_m1_q) begin
							j_n = j_q + 1'b1;
						end else begin
							j_n = '0;
							if (i_q != ar_m1_q) begin
								i_n = i_q + 1'b1;
							end else begin
								i_n     = '0;
								state_n = mm_pkg::ST_IDLE;
							end
						end
					end
				end
			end
			default: begin
				state_n = mm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			a_mem[wr_addr] <= wv;
		end
		if (we_b) begin
			b_mem[wr_addr] <= wv;
		end
		if (adv) begin
			a_rd_s1 <= a_mem[ra];
			b_rd_s1 <= b_mem[rb];
		end
	end

	assign b_lo = signed'({1'b0, b_rd_s1[H-1:0]});
	assign b_hi = b_rd_s1[VB-1:H];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			tag_s3      <= '0;
			emit_s4     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			tag_s1      <= iss;
			tag_s2      <= tag_s1;
			tag_s3      <= tag_s2;
			emit_s4     <= tag_s3.valid && tag_s3.lastk;
			out_valid_q <= emit_s4;
		end
	end

	assign acc_base = tag_s3.first ? ACC_W'(0) : acc_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_lo_s2 <= a_rd_s1 * b_lo;
			p_hi_s2 <= a_rd_s1 * b_hi;
			prod_s3 <= (PW'(p_hi_s2) <<< H) + PW'(p_lo_s2);
			if (tag_s3.valid) begin
				acc_s4 <= acc_base + ACC_W'(prod_s3);
			end
			err_s4  <= tag_s3.err;
			last_s4 <= tag_s3.last;
			row_s4  <= tag_s3.row;
			col_s4  <= tag_s3.col;
		end
	end

	always_comb begin
		t_sh = TW'(acc_s4 >>> mm_pkg::FRAC_BITS);
		t_hi = t_sh[TW-1:VB-1];
		if ((&t_hi) || !(|t_hi)) begin
			sat = t_sh[VB-1:0];
		end else if (t_sh[TW-1]) begin
			sat = {1'b1, {(VB-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VB-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_row    <= err_s4 ? 3'd0 : row_s4;
			out_q.out_col    <= err_s4 ? 3'd0 : col_s4;
			out_q.out_value  <= err_s4 ? 32'sd0 : signed'(32'(sat));
			out_q.size_error <= err_s4;
			out_q.last       <= last_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/core/matrix_multiply.sv -----
// Fixed-point matrix product C = A * B on signed Q16.16 entries. Command items
// write single entries of A or B, or request a product; they enter a four-entry
// queue at one per cycle while the queue has room, so entry writes stream at full
// rate while the back end is idle and the output is not stalled. The back end
// executes queued items in order; a product walks a_rows * b_cols * a_cols
// multiply-accumulates (used sizes), one per cycle while the output is not
// stalled, through a single pipeline of two partial-product multipliers fed by
// one read port on each store, emitting C row-major with last set on the final
// entry. Each entry is the exact sum of products, shifted right by 16 and
// saturated. When the used A column count differs from the used B row count,
// a single result with size_error and last set is emitted. Size registers of
// zero act as one and sizes above MAX_DIM act as MAX_DIM; store entries hold no
// defined value until written, so every entry a product uses must be written
// first. Write the size registers only while no item is in flight.
module matrix_multiply #(
	parameter int MAX_DIM    = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mm_pkg::in_item_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mm_pkg::out_item_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_wdata
);

	mm_pkg::dims_t   dims_q;
	mm_pkg::q_stat_t q_stat;
	mm_pkg::job_t    push_data;
	mm_pkg::job_t    pop_data;
	logic            push;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.a_rows <= mm_pkg::DIM_RESET;
			dims_q.a_cols <= mm_pkg::DIM_RESET;
			dims_q.b_rows <= mm_pkg::DIM_RESET;
			dims_q.b_cols <= mm_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mm_pkg::CFG_A_ROWS: begin
					dims_q.a_rows <= cfg_wdata;
				end
				mm_pkg::CFG_A_COLS: begin
					dims_q.a_cols <= cfg_wdata;
				end
				mm_pkg::CFG_B_ROWS: begin
					dims_q.b_rows <= cfg_wdata;
				end
				mm_pkg::CFG_B_COLS: begin
					dims_q.b_cols <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	mm_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	mm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	mm_back #(
		.MAX_DIM    (MAX_DIM),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims_q),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- tb/tb_matrix_multiply.sv -----
`timescale 1ns / 1ps

module tb_matrix_multiply;

	localparam int MAX_DIM = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEM_TARGET = 350;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint Q_MAX = 64'sh7fffffff;
	localparam longint Q_MIN = -64'sh80000000;

	class mm_scoreboard;
		logic signed [31:0] a_mem [MAX_DIM][MAX_DIM];
		logic signed [31:0] b_mem [MAX_DIM][MAX_DIM];
		mm_pkg::dims_t dims;
		mm_pkg::out_item_t product_queue [$];
		int errors;

		function new();
			dims = '{mm_pkg::DIM_RESET, mm_pkg::DIM_RESET, mm_pkg::DIM_RESET,
				mm_pkg::DIM_RESET};
			errors = 0;
		endfunction

		static function int used_dim(logic [3:0] d);
			if (d == 0)
				return 1;
			if (d > MAX_DIM)
				return MAX_DIM;
			return int'(d);
		endfunction

		function void set_dim(logic [1:0] idx, logic [3:0] v);
			case (idx)
				mm_pkg::CFG_A_ROWS: dims.a_rows = v;
				mm_pkg::CFG_A_COLS: dims.a_cols = v;
				mm_pkg::CFG_B_ROWS: dims.b_rows = v;
				mm_pkg::CFG_B_COLS: dims.b_cols = v;
				default: ;
			endcase
		endfunction

		function logic signed [31:0] dot_entry(int r, int c, int depth);
			logic signed [79:0] acc;
			logic signed [79:0] shifted;
			acc = '0;
			for (int k = 0; k < depth; k++)
				acc = acc + a_mem[r][k] * b_mem[k][c];
			shifted = acc >>> 16;
			if (shifted > Q_MAX)
				return 32'h7fffffff;
			if (shifted < Q_MIN)
				return 32'h80000000;
			return shifted[31:0];
		endfunction

		function void note_item(mm_pkg::in_item_t it);
			mm_pkg::out_item_t res;
			int ar, ac, br, bc;
			case (it.command)
				mm_pkg::CMD_WR_A: a_mem[it.row_index][it.col_index] = it.entry_value;
				mm_pkg::CMD_WR_B: b_mem[it.row_index][it.col_index] = it.entry_value;
				mm_pkg::CMD_CALC: begin
					ar = used_dim(dims.a_rows);
					ac = used_dim(dims.a_cols);
					br = used_dim(dims.b_rows);
					bc = used_dim(dims.b_cols);
					if (ac != br) begin
						res = '0;
						res.size_error = 1'b1;
						res.last = 1'b1;
						product_queue.push_back(res);
					end else begin
						for (int i = 0; i < ar; i++) begin
							for (int j = 0; j < bc; j++) begin
								res = '0;
								res.out_row = 3'(i);
								res.out_col = 3'(j);
								res.out_value = dot_entry(i, j, ac);
								res.last = (i == ar - 1) && (j == bc - 1);
								product_queue.push_back(res);
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("%0t MISMATCH %s", $realtime, msg);
			errors++;
		endtask

		task check_entry(mm_pkg::out_item_t got);
			mm_pkg::out_item_t want;
			if (product_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected item %p", got));
				return;
			end
			want = product_queue.pop_front();
			if (got.out_row !== want.out_row)
				report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
			if (got.out_col !== want.out_col)
				report_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
			if (got.out_value !== want.out_value)
				report_mismatch($sformatf("out_value %h, want %h at (%0d,%0d)",
					got.out_value, want.out_value, want.out_row, want.out_col));
			if (got.size_error !== want.size_error)
				report_mismatch($sformatf("size_error %b, want %b", got.size_error,
					want.size_error));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, want %b at (%0d,%0d)", got.last,
					want.last, want.out_row, want.out_col));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	mm_pkg::in_item_t in_data = '0;
	logic out_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_wdata = '0;
	logic in_ready;
	logic out_valid;
	mm_pkg::out_item_t out_data;

	mm_scoreboard sb = new();
	bit no_idle = 1'b0;
	bit a_written [MAX_DIM * MAX_DIM];
	bit b_written [MAX_DIM * MAX_DIM];
	int items_accepted = 0;

	matrix_multiply u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	function bit idle_now();
		return !no_idle && ($urandom_range(99) < 16);
	endfunction

	function logic [31:0] rand_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(0, 32'h7ffff) - 32'h40000;
			4, 5, 6: return $urandom;
			7: return ($urandom_range(0, 64) - 32) << 16;
			default: begin
				case ($urandom_range(4))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h00000000;
					3: return 32'hffffffff;
					default: return 32'h00010000;
				endcase
			end
		endcase
	endfunction

	function logic [3:0] rand_dim();
		if ($urandom_range(9) < 8)
			return 4'($urandom_range(1, 4));
		return 4'($urandom_range(0, 15));
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_entry(out_data);
			out_ready <= !idle_now();
		end
	end

	task send_item(mm_pkg::in_item_t it);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		if (it.command inside {mm_pkg::CMD_WR_A, mm_pkg::CMD_WR_B, mm_pkg::CMD_CALC})
			items_accepted++;
	endtask

	task write_entry(mm_pkg::cmd_t cmd, int r, int c, logic [31:0] v);
		mm_pkg::in_item_t it;
		it.command = cmd;
		it.row_index = 3'(r);
		it.col_index = 3'(c);
		it.entry_value = v;
		send_item(it);
		if (cmd == mm_pkg::CMD_WR_A)
			a_written[r * MAX_DIM + c] = 1'b1;
		else
			b_written[r * MAX_DIM + c] = 1'b1;
	endtask

	task send_noise();
		mm_pkg::in_item_t it;
		it.command = CMD_UNUSED;
		it.row_index = 3'($urandom);
		it.col_index = 3'($urandom);
		it.entry_value = $urandom;
		send_item(it);
	endtask

	task compute();
		int ar, ac, br, bc;
		mm_pkg::in_item_t it;
		ar = mm_scoreboard::used_dim(sb.dims.a_rows);
		ac = mm_scoreboard::used_dim(sb.dims.a_cols);
		br = mm_scoreboard::used_dim(sb.dims.b_rows);
		bc = mm_scoreboard::used_dim(sb.dims.b_cols);
		// fill every entry the product reads that was never written
		if (ac == br) begin
			for (int r = 0; r < ar; r++)
				for (int k = 0; k < ac; k++)
					if (!a_written[r * MAX_DIM + k])
						write_entry(mm_pkg::CMD_WR_A, r, k, rand_value());
			for (int k = 0; k < br; k++)
				for (int c = 0; c < bc; c++)
					if (!b_written[k * MAX_DIM + c])
						write_entry(mm_pkg::CMD_WR_B, k, c, rand_value());
		end
		it.command = mm_pkg::CMD_CALC;
		it.row_index = 3'($urandom);
		it.col_index = 3'($urandom);
		it.entry_value = $urandom;
		send_item(it);
	endtask

	task random_item();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			send_noise();
		else if (sel == 1)
			write_entry($urandom_range(1) ? mm_pkg::CMD_WR_A : mm_pkg::CMD_WR_B,
				$urandom_range(7), $urandom_range(7), rand_value());
		else if ($urandom_range(1))
			write_entry(mm_pkg::CMD_WR_A,
				$urandom_range(mm_scoreboard::used_dim(sb.dims.a_rows) - 1),
				$urandom_range(mm_scoreboard::used_dim(sb.dims.a_cols) - 1), rand_value());
		else
			write_entry(mm_pkg::CMD_WR_B,
				$urandom_range(mm_scoreboard::used_dim(sb.dims.b_rows) - 1),
				$urandom_range(mm_scoreboard::used_dim(sb.dims.b_cols) - 1), rand_value());
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.product_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task cfg_write(logic [1:0] idx, logic [3:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_dim(idx, v);
	endtask

	task set_dims(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
		drain();
		cfg_write(mm_pkg::CFG_A_ROWS, ar);
		cfg_write(mm_pkg::CFG_A_COLS, ac);
		cfg_write(mm_pkg::CFG_B_ROWS, br);
		cfg_write(mm_pkg::CFG_B_COLS, bc);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase_no;
		logic [3:0] ar, ac, br, bc;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_dims(4'd1, 4'd1, 4'd1, 4'd1);
		write_entry(mm_pkg::CMD_WR_A, 0, 0, 32'h7fffffff);
		write_entry(mm_pkg::CMD_WR_B, 0, 0, 32'h7fffffff);
		compute();
		write_entry(mm_pkg::CMD_WR_B, 0, 0, 32'h80000000);
		compute();
		write_entry(mm_pkg::CMD_WR_A, 0, 0, 32'hffffffff);
		write_entry(mm_pkg::CMD_WR_B, 0, 0, 32'h00000001);
		compute();
		write_entry(mm_pkg::CMD_WR_A, 7, 7, 32'h00000000);
		write_entry(mm_pkg::CMD_WR_B, 7, 7, 32'h55555555);
		send_noise();
		set_dims(4'd1, 4'd2, 4'd1, 4'd1);
		compute();
		set_dims(4'd0, 4'd0, 4'd0, 4'd0);
		compute();

		phase_no = 0;
		while (items_accepted < ITEM_TARGET) begin
			no_idle = (phase_no >= 6) && (phase_no < 12);
			if (phase_no == 2) begin
				ar = 4'd15; ac = 4'd15; br = 4'd15; bc = 4'd15;
			end else if (phase_no == 4) begin
				ar = 4'd8; ac = 4'd8; br = 4'd9; bc = 4'd8;
			end else begin
				ar = rand_dim();
				ac = rand_dim();
				bc = rand_dim();
				br = ac;
				if (ac >= MAX_DIM)
					br = 4'($urandom_range(MAX_DIM, 15));
				else if (ac <= 1)
					br = 4'($urandom_range(0, 1));
				if ($urandom_range(9) >= 8)
					br = rand_dim();
			end
			set_dims(ar, ac, br, bc);
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 6)) random_item();
				compute();
			end
			phase_no++;
		end
		no_idle = 1'b0;
		drain();

		if (sb.errors == 0)
			$display("tb_matrix_multiply passed");
		else
			$display("tb_matrix_multiply failed");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("tb_matrix_multiply failed");
		$finish;
	end

endmodule
